FILE: rtl/plnt_pkg.sv
// Shared types, codes and helpers for the packet loss / NACK tracker.
// No dependencies; imported by plnt_slot_mem, plnt_ctrl and the top level.
package plnt_pkg;

    localparam int WINDOW_DEF = 256;

    // item actions
    localparam logic [1:0] ACT_OBSERVE = 2'd0;
    localparam logic [1:0] ACT_COLLECT = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_WINDOW = 3'd1;
    localparam logic [2:0] ERR_FULL   = 3'd2;
    localparam logic [2:0] ERR_PT     = 3'd3;
    localparam logic [2:0] ERR_AMBIG  = 3'd4;

    // observe classification
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_FIRST     = 3'd1;
    localparam logic [2:0] KIND_IN_ORDER  = 3'd2;
    localparam logic [2:0] KIND_GAP       = 3'd3;
    localparam logic [2:0] KIND_DUPLICATE = 3'd4;
    localparam logic [2:0] KIND_RECOVERED = 3'd5;
    localparam logic [2:0] KIND_TOO_OLD   = 3'd6;

    // slot states
    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_RECEIVED = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;

    // serial-number compare results
    localparam logic [1:0] CMP_EQUAL = 2'd0;
    localparam logic [1:0] CMP_NEWER = 2'd1;
    localparam logic [1:0] CMP_OLDER = 2'd2;
    localparam logic [1:0] CMP_AMBIG = 2'd3;

    // register indexes
    localparam logic [1:0] REG_REORDER   = 2'd0;
    localparam logic [1:0] REG_RENACK    = 2'd1;
    localparam logic [1:0] REG_MAX_ATT   = 2'd2;
    localparam logic [1:0] REG_MAX_OUT   = 2'd3;

    typedef struct packed {
        logic [1:0]  state;
        logic [7:0]  att;
        logic [63:0] since;
        logic [63:0] last_nack;
    } slot_t;

    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        slot_t wr_data;
    } mem_ctl_t;

    function automatic logic [1:0] seq_cmp(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            if (d == 32'd0)
                seq_cmp = CMP_EQUAL;
            else if (d == 32'h8000_0000)
                seq_cmp = CMP_AMBIG;
            else if (d[31] == 1'b0)
                seq_cmp = CMP_NEWER;
            else
                seq_cmp = CMP_OLDER;
        end
    endfunction

endpackage

FILE: rtl/plnt_slot_mem.sv
// Slot memory: one entry per window slot, one write and one read port.
// Depends on plnt_pkg for the slot entry layout.
module plnt_slot_mem #(
    parameter int W  = plnt_pkg::WINDOW_DEF,
    parameter int IW = 8
) (
    input  logic                clk,
    input  plnt_pkg::mem_ctl_t  ctl,
    input  logic [IW-1:0]       wr_addr,
    input  logic [IW-1:0]       rd_addr,
    output plnt_pkg::slot_t     rd_data
);
    import plnt_pkg::*;

    slot_t mem [W];

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= ctl.wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/plnt_ctrl.sv
// Sequencer of the tracker: window registers, observe/collect/query flows
// and the result registers. Depends on plnt_pkg; drives plnt_slot_mem.
module plnt_ctrl #(
    parameter int W  = plnt_pkg::WINDOW_DEF,
    parameter int IW = 8,
    parameter int CW = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [31:0]        sequence_req,
    input  logic [63:0]        now_us,
    input  logic [7:0]         payload_type,
    input  logic [31:0]        reorder_delay,
    input  logic [31:0]        renack_interval,
    input  logic [7:0]         max_att,
    input  logic [5:0]         max_out,
    output plnt_pkg::mem_ctl_t mem_ctl,
    output logic [IW-1:0]      wr_addr,
    output logic [IW-1:0]      rd_addr,
    input  plnt_pkg::slot_t    rd_data,
    output logic               result_valid,
    output logic [2:0]         error,
    output logic [2:0]         kind,
    output logic [31:0]        seq_out,
    output logic [8:0]         count,
    output logic [8:0]         missing_total,
    output logic [63:0]        nack_bitmap,
    output logic [6:0]         nack_payload_type,
    output logic [1:0]         slot_status,
    output logic [7:0]         slot_nack_count,
    output logic [63:0]        slot_missing_since,
    output logic [63:0]        slot_last_nack_time,
    output logic               last
);
    import plnt_pkg::*;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DEC     = 4'd2;
    localparam logic [3:0] S_OEVAL   = 4'd3;
    localparam logic [3:0] S_QEVAL   = 4'd4;
    localparam logic [3:0] S_ECHK_RD = 4'd5;
    localparam logic [3:0] S_ECHK_EV = 4'd6;
    localparam logic [3:0] S_EVICT   = 4'd7;
    localparam logic [3:0] S_GAP     = 4'd8;
    localparam logic [3:0] S_RECV    = 4'd9;
    localparam logic [3:0] S_WRD     = 4'd10;
    localparam logic [3:0] S_WCHK    = 4'd11;
    localparam logic [3:0] S_WEND    = 4'd12;
    localparam logic [3:0] S_SUM     = 4'd13;

    localparam logic [CW-1:0] WIN    = CW'(W);
    localparam logic [IW-1:0] IDX_TOP = IW'(W - 1);

    // index helpers: a < W, b <= W
    function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        begin
            s = (CW+1)'(a) + (CW+1)'(b);
            if (s >= (CW+1)'(W))
                s = s - (CW+1)'(W);
            idx_add = s[IW-1:0];
        end
    endfunction

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
        idx_inc = (a == IDX_TOP) ? '0 : a + IW'(1);
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] need_reg, need_next;
    logic [CW-1:0] d_reg, d_next;
    logic [31:0]   oldest_reg, oldest_next;
    logic [31:0]   frontier_reg, frontier_next;
    logic [IW-1:0] oidx_reg, oidx_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [CW-1:0] tracked_reg, tracked_next;
    logic [CW-1:0] missing_reg, missing_next;
    logic          started_reg, started_next;
    logic [1:0]    act_reg, act_next;
    logic [31:0]   seq_reg, seq_next;
    logic [63:0]   now_reg, now_next;
    logic [7:0]    pt_reg, pt_next;
    logic          pend_reg, pend_next;
    logic [31:0]   base_reg, base_next;
    logic [63:0]   map_reg, map_next;
    logic [6:0]    written_reg, written_next;
    logic [CW-1:0] v_reg, v_next;
    logic [31:0]   s_reg, s_next;
    logic [2:0]    err_reg, err_next;

    // result fields to load this cycle
    logic          emit;
    logic [2:0]    e_err, e_kind;
    logic [31:0]   e_seq;
    logic [8:0]    e_count;
    logic [63:0]   e_bitmap;
    logic [6:0]    e_pt;
    logic [1:0]    e_status;
    logic [7:0]    e_att;
    logic [63:0]   e_since, e_lastn;
    logic          e_last;

    // scratch for decode and walk
    logic [1:0]    c_f, c_o;
    logic [31:0]   d32, dist32, off32;
    logic [CW:0]   sum_td;
    logic [IW-1:0] old_idx;
    logic [63:0]   elapsed, ref_time;
    logic          due;
    logic [6:0]    wr_after;
    logic [CW+8:0] miss_ext;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        need_next     = need_reg;
        d_next        = d_reg;
        oldest_next   = oldest_reg;
        frontier_next = frontier_reg;
        oidx_next     = oidx_reg;
        fidx_next     = fidx_reg;
        tracked_next  = tracked_reg;
        missing_next  = missing_reg;
        started_next  = started_reg;
        act_next      = act_reg;
        seq_next      = seq_reg;
        now_next      = now_reg;
        pt_next       = pt_reg;
        pend_next     = pend_reg;
        base_next     = base_reg;
        map_next      = map_reg;
        written_next  = written_reg;
        v_next        = v_reg;
        s_next        = s_reg;
        err_next      = err_reg;

        mem_ctl       = '0;
        wr_addr       = ptr_reg;
        rd_addr       = ptr_reg;

        emit     = 1'b0;
        e_err    = ERR_NONE;
        e_kind   = KIND_NONE;
        e_seq    = '0;
        e_count  = '0;
        e_bitmap = '0;
        e_pt     = '0;
        e_status = ST_EMPTY;
        e_att    = '0;
        e_since  = '0;
        e_lastn  = '0;
        e_last   = 1'b0;

        c_f      = seq_cmp(seq_reg, frontier_reg);
        c_o      = seq_cmp(seq_reg, oldest_reg);
        d32      = seq_reg - frontier_reg;
        dist32   = frontier_reg - seq_reg;
        sum_td   = (CW+1)'(tracked_reg) + (CW+1)'(d32[CW-1:0]);
        old_idx  = idx_add(fidx_reg, WIN - dist32[CW-1:0]);
        off32    = s_reg - base_reg;
        ref_time = (rd_data.att == 8'd0) ? rd_data.since : rd_data.last_nack;
        elapsed  = (now_reg >= ref_time) ? now_reg - ref_time : 64'd0;
        if (rd_data.att >= max_att)
            due = 1'b0;
        else if (rd_data.att == 8'd0)
            due = elapsed >= {32'd0, reorder_delay};
        else
            due = elapsed >= {32'd0, renack_interval};
        wr_after = written_reg;

        case (state_reg)
            // clearing pass after reset
            S_CLR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_data = '0;
                ptr_next        = idx_inc(ptr_reg);
                if (ptr_reg == IDX_TOP)
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    seq_next   = sequence_req;
                    now_next   = now_us;
                    pt_next    = payload_type;
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                state_next = S_IDLE;
                e_last     = 1'b1;
                e_seq      = seq_reg;
                case (act_reg)
                    ACT_OBSERVE:
                    begin
                        emit = 1'b1;
                        if (!started_reg)
                        begin
                            ptr_next        = '0;
                            wr_addr         = '0;
                            mem_ctl.wr_en   = 1'b1;
                            mem_ctl.wr_data = '{state: ST_RECEIVED, att: 8'd0,
                                                since: 64'd0, last_nack: 64'd0};
                            oldest_next     = seq_reg;
                            frontier_next   = seq_reg;
                            oidx_next       = '0;
                            fidx_next       = '0;
                            tracked_next    = CW'(1);
                            missing_next    = '0;
                            started_next    = 1'b1;
                            e_kind          = KIND_FIRST;
                        end
                        else if (c_f == CMP_AMBIG)
                            e_err = ERR_AMBIG;
                        else if (c_f == CMP_EQUAL)
                            e_kind = KIND_DUPLICATE;
                        else if (c_f == CMP_NEWER)
                        begin
                            if (d32 > 32'(W))
                                e_err = ERR_WINDOW;
                            else
                            begin
                                emit   = 1'b0;
                                d_next = d32[CW-1:0];
                                if (sum_td > (CW+1)'(W))
                                begin
                                    need_next  = CW'(sum_td - (CW+1)'(W));
                                    k_next     = '0;
                                    ptr_next   = oidx_reg;
                                    state_next = S_ECHK_RD;
                                end
                                else
                                begin
                                    need_next = '0;
                                    k_next    = CW'(1);
                                    ptr_next  = idx_inc(fidx_reg);
                                    state_next = (d32 == 32'd1) ? S_RECV : S_GAP;
                                end
                            end
                        end
                        else if (c_o == CMP_AMBIG)
                            e_err = ERR_AMBIG;
                        else if (c_o == CMP_OLDER)
                            e_kind = KIND_TOO_OLD;
                        else
                        begin
                            emit          = 1'b0;
                            ptr_next      = old_idx;
                            rd_addr       = old_idx;
                            mem_ctl.rd_en = 1'b1;
                            state_next    = S_OEVAL;
                        end
                    end

                    ACT_COLLECT:
                    begin
                        if (pt_reg > 8'd127)
                        begin
                            err_next   = ERR_PT;
                            written_next = '0;
                            state_next = S_SUM;
                        end
                        else if (!started_reg || missing_reg == '0)
                        begin
                            err_next   = ERR_NONE;
                            written_next = '0;
                            state_next = S_SUM;
                        end
                        else
                        begin
                            err_next     = ERR_NONE;
                            written_next = '0;
                            pend_next    = 1'b0;
                            map_next     = '0;
                            ptr_next     = oidx_reg;
                            s_next       = oldest_reg;
                            v_next       = '0;
                            state_next   = S_WRD;
                        end
                    end

                    ACT_QUERY:
                    begin
                        emit = 1'b1;
                        // oldest bound is tested before the frontier bound
                        if (!started_reg || tracked_reg == '0)
                            e_err = ERR_NONE;
                        else if (c_o == CMP_AMBIG)
                            e_err = ERR_AMBIG;
                        else if (c_o == CMP_OLDER)
                            e_err = ERR_NONE;
                        else if (c_f == CMP_AMBIG)
                            e_err = ERR_AMBIG;
                        else if (c_f == CMP_NEWER)
                            e_err = ERR_NONE;
                        else
                        begin
                            emit          = 1'b0;
                            rd_addr       = old_idx;
                            mem_ctl.rd_en = 1'b1;
                            state_next    = S_QEVAL;
                        end
                    end

                    default:
                    begin
                        emit  = 1'b1;
                        e_seq = '0;
                    end
                endcase
            end

            // older packet inside the window
            S_OEVAL:
            begin
                emit       = 1'b1;
                e_last     = 1'b1;
                e_seq      = seq_reg;
                state_next = S_IDLE;
                if (rd_data.state == ST_MISSING)
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_data = '{state: ST_RECEIVED, att: 8'd0,
                                        since: 64'd0, last_nack: 64'd0};
                    if (missing_reg != '0)
                        missing_next = missing_reg - CW'(1);
                    e_kind = KIND_RECOVERED;
                end
                else if (rd_data.state == ST_RECEIVED)
                    e_kind = KIND_DUPLICATE;
                else
                    e_kind = KIND_TOO_OLD;
            end

            S_QEVAL:
            begin
                emit       = 1'b1;
                e_last     = 1'b1;
                e_seq      = seq_reg;
                e_status   = rd_data.state;
                e_att      = rd_data.att;
                e_since    = rd_data.since;
                e_lastn    = rd_data.last_nack;
                state_next = S_IDLE;
            end

            // refuse an advance that would evict a missing slot
            S_ECHK_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_ECHK_EV;
            end

            S_ECHK_EV:
            begin
                if (rd_data.state == ST_MISSING)
                begin
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    e_seq      = seq_reg;
                    e_err      = ERR_WINDOW;
                    state_next = S_IDLE;
                end
                else if (k_reg + CW'(1) == need_reg)
                begin
                    k_next     = '0;
                    ptr_next   = oidx_reg;
                    state_next = S_EVICT;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    ptr_next   = idx_inc(ptr_reg);
                    state_next = S_ECHK_RD;
                end
            end

            // clear the oldest slots
            S_EVICT:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_data = '0;
                k_next          = k_reg + CW'(1);
                ptr_next        = idx_inc(ptr_reg);
                if (k_reg + CW'(1) == need_reg)
                begin
                    oidx_next  = idx_inc(ptr_reg);
                    k_next     = CW'(1);
                    ptr_next   = idx_inc(fidx_reg);
                    state_next = (d_reg == CW'(1)) ? S_RECV : S_GAP;
                end
            end

            // mark skipped numbers missing
            S_GAP:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_data = '{state: ST_MISSING, att: 8'd0,
                                    since: now_reg, last_nack: 64'd0};
                k_next          = k_reg + CW'(1);
                ptr_next        = idx_inc(ptr_reg);
                if (k_reg + CW'(1) == d_reg)
                    state_next = S_RECV;
            end

            S_RECV:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_data = '{state: ST_RECEIVED, att: 8'd0,
                                    since: 64'd0, last_nack: 64'd0};
                fidx_next       = ptr_reg;
                frontier_next   = seq_reg;
                oldest_next     = oldest_reg + 32'(need_reg);
                tracked_next    = tracked_reg - need_reg + d_reg;
                missing_next    = missing_reg + d_reg - CW'(1);
                emit            = 1'b1;
                e_last          = 1'b1;
                e_seq           = seq_reg;
                e_kind          = (d_reg == CW'(1)) ? KIND_IN_ORDER : KIND_GAP;
                e_count         = 9'(32'(d_reg) - 32'd1);
                state_next      = S_IDLE;
            end

            // collect walk: read a slot, then check and update it
            S_WRD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_WCHK;
            end

            S_WCHK:
            begin
                state_next = S_WRD;
                if (rd_data.state == ST_MISSING && due)
                begin
                    if (pend_reg && off32 < 32'd64)
                    begin
                        map_next = map_reg | (64'd1 << off32[5:0]);
                    end
                    else
                    begin
                        // close the open request, then open a new one
                        if (pend_reg)
                        begin
                            emit     = 1'b1;
                            e_seq    = base_reg;
                            e_bitmap = map_reg;
                            e_pt     = pt_reg[6:0];
                            wr_after = written_reg + 7'd1;
                        end
                        written_next = wr_after;
                        base_next    = s_reg;
                        map_next     = 64'd1;
                        pend_next    = 1'b1;
                    end
                    if (pend_reg && off32 >= 32'd64 && wr_after >= {1'b0, max_out} ||
                        !pend_reg && wr_after >= {1'b0, max_out})
                    begin
                        err_next   = ERR_FULL;
                        pend_next  = 1'b0;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        // this slot's request will go out: count the attempt now
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_data = '{state: ST_MISSING, att: rd_data.att + 8'd1,
                                            since: rd_data.since, last_nack: now_reg};
                    end
                end
                if (state_next == S_WRD)
                begin
                    v_next   = v_reg + CW'(1);
                    s_next   = s_reg + 32'd1;
                    ptr_next = idx_inc(ptr_reg);
                    if (v_reg + CW'(1) == tracked_reg)
                        state_next = S_WEND;
                end
            end

            S_WEND:
            begin
                if (pend_reg)
                begin
                    emit         = 1'b1;
                    e_seq        = base_reg;
                    e_bitmap     = map_reg;
                    e_pt         = pt_reg[6:0];
                    written_next = written_reg + 7'd1;
                end
                state_next = S_SUM;
            end

            S_SUM:
            begin
                emit       = 1'b1;
                e_last     = 1'b1;
                e_err      = err_reg;
                e_count    = 9'(written_reg);
                state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase

        miss_ext = (CW+9)'(missing_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            ptr_reg      <= '0;
            oldest_reg   <= '0;
            frontier_reg <= '0;
            oidx_reg     <= '0;
            fidx_reg     <= '0;
            tracked_reg  <= '0;
            missing_reg  <= '0;
            started_reg  <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            oldest_reg   <= oldest_next;
            frontier_reg <= frontier_next;
            oidx_reg     <= oidx_next;
            fidx_reg     <= fidx_next;
            tracked_reg  <= tracked_next;
            missing_reg  <= missing_next;
            started_reg  <= started_next;
            result_valid <= emit;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        need_reg    <= need_next;
        d_reg       <= d_next;
        act_reg     <= act_next;
        seq_reg     <= seq_next;
        now_reg     <= now_next;
        pt_reg      <= pt_next;
        pend_reg    <= pend_next;
        base_reg    <= base_next;
        map_reg     <= map_next;
        written_reg <= written_next;
        v_reg       <= v_next;
        s_reg       <= s_next;
        err_reg     <= err_next;
        if (emit)
        begin
            error               <= e_err;
            kind                <= e_kind;
            seq_out             <= e_seq;
            count               <= e_count;
            missing_total       <= miss_ext[8:0];
            nack_bitmap         <= e_bitmap;
            nack_payload_type   <= e_pt;
            slot_status         <= e_status;
            slot_nack_count     <= e_att;
            slot_missing_since  <= e_since;
            slot_last_nack_time <= e_lastn;
            last                <= e_last;
        end
    end

endmodule

FILE: rtl/packet_loss_nack_tracker_top.sv
// Top level of the packet loss / NACK tracker: configuration registers,
// slot memory and sequencer. Depends on plnt_pkg, plnt_slot_mem, plnt_ctrl.
//
// Usage:
//   An item is taken when start is high and busy is low. action selects
//   observe (0), collect (1) or query (2). Results appear on the result
//   ports with result_valid high for exactly one cycle; last marks the
//   final result of an item. The receiver cannot stall the block.
//   Observe of a newer number checks each slot that it must evict, then
//   clears those slots, then marks the skipped numbers missing.
//   Collect walks the tracked slots (read then update of the slot memory)
//   and the walk ends early when the output is full.
//   busy stays high until the last result is registered; a new item may be
//   started in the cycle that result is shown.
//   Reset: a clearing pass writes every slot empty with busy high.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) are taken in any
//   cycle, including that pass.
module packet_loss_nack_tracker_top #(
    parameter int WINDOW = plnt_pkg::WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] sequence_req,
    input  logic [63:0] now_us,
    input  logic [7:0]  payload_type,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output logic        result_valid,
    output logic [2:0]  error,
    output logic [2:0]  kind,
    output logic [31:0] seq_out,
    output logic [8:0]  count,
    output logic [8:0]  missing_total,
    output logic [63:0] nack_bitmap,
    output logic [6:0]  nack_payload_type,
    output logic [1:0]  slot_status,
    output logic [7:0]  slot_nack_count,
    output logic [63:0] slot_missing_since,
    output logic [63:0] slot_last_nack_time,
    output logic        last
);
    import plnt_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    logic [31:0]   reorder_reg;
    logic [31:0]   renack_reg;
    logic [7:0]    max_att_reg;
    logic [5:0]    max_out_reg;

    mem_ctl_t      mem_ctl;
    logic [IW-1:0] wr_addr, rd_addr;
    slot_t         rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reorder_reg <= '0;
            renack_reg  <= '0;
            max_att_reg <= 8'd3;
            max_out_reg <= 6'd16;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REORDER: reorder_reg <= cfg_wdata;
                REG_RENACK:  renack_reg  <= cfg_wdata;
                REG_MAX_ATT: max_att_reg <= cfg_wdata[7:0];
                REG_MAX_OUT: max_out_reg <= cfg_wdata[5:0];
                default:     reorder_reg <= reorder_reg;
            endcase
        end
    end

    plnt_slot_mem #(.W(WINDOW), .IW(IW)) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    plnt_ctrl #(.W(WINDOW), .IW(IW), .CW(CW)) u_ctrl (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .action              (action),
        .sequence_req        (sequence_req),
        .now_us              (now_us),
        .payload_type        (payload_type),
        .reorder_delay       (reorder_reg),
        .renack_interval     (renack_reg),
        .max_att             (max_att_reg),
        .max_out             (max_out_reg),
        .mem_ctl             (mem_ctl),
        .wr_addr             (wr_addr),
        .rd_addr             (rd_addr),
        .rd_data             (rd_data),
        .result_valid        (result_valid),
        .error               (error),
        .kind                (kind),
        .seq_out             (seq_out),
        .count               (count),
        .missing_total       (missing_total),
        .nack_bitmap         (nack_bitmap),
        .nack_payload_type   (nack_payload_type),
        .slot_status         (slot_status),
        .slot_nack_count     (slot_nack_count),
        .slot_missing_since  (slot_missing_since),
        .slot_last_nack_time (slot_last_nack_time),
        .last                (last)
    );

endmodule

FILE: rtl/plnt_checker.sv
// Port-level checks of the tracker, bound to the top level.
// Depends only on the top level's ports.
module plnt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  error,
    input logic [2:0]  kind,
    input logic        last
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // NACK requests come from a running walk
    a_nack_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("NACK result outside a collect");

    // NACK requests carry no error and no kind
    a_nack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> error == 3'd0 && kind == 3'd0)
        else $error("NACK result with error or kind");

    // the final result frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("still busy on final result");

endmodule

bind packet_loss_nack_tracker_top plnt_checker u_plnt_checker (.*);
